FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the tremolo block. Every check
// is sampled on clk and is off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold on every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Overlapping implication: the consequent holds in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Non-overlapping implication: the consequent holds in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/tlam_pkg.sv
// ----------------------------------------------------------------------------
// tlam_pkg
// Constants, register codes, types and the sine table generator shared by the
// tremolo modulator modules.
// ----------------------------------------------------------------------------
package tlam_pkg;

	// Defaults for the top-level parameters.
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int PHASE_BITS_DEF  = 24;
	localparam int SINE_ENTRIES_DEF = 1024;

	// Register widths and configuration port.
	localparam int STEP_W     = 24;
	localparam int DEPTH_W    = 16;
	localparam int WAVE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM   = 2'd2;

	localparam logic [STEP_W-1:0]  STEP_RESET  = 24'd699;
	localparam logic [DEPTH_W-1:0] DEPTH_RESET = 16'd32768;

	// Waveform codes.
	localparam logic [WAVE_W-1:0] WAVE_SINE     = 2'd0;
	localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd1;
	localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 2'd2;
	localparam logic [WAVE_W-1:0] WAVE_SLOPED   = 2'd3;
	localparam logic [WAVE_W-1:0] WAVE_RESET    = WAVE_SINE;

	// LFO values are Q1.15 from 0 to 1.0.
	localparam int LFO_W = 16;
	localparam logic [LFO_W-1:0] LFO_ONE = 16'd32768;
	localparam logic [LFO_W-1:0] LFO_MID = 16'd16384;

	// Quarter-wave sine magnitude, 0 to 16384.
	localparam int MAG_W = 15;
	localparam logic [MAG_W-1:0] MAG_MAX = 15'd16384;

	// 2*pi in Q3.30.
	localparam longint unsigned Q30_TWO_PI = 64'd6746518852;

	// Slope of the sloped square edges: 50 * 32768.
	localparam int SLOPE_GAIN_W = 21;
	localparam logic [SLOPE_GAIN_W-1:0] SLOPE_GAIN = 21'd1638400;

	// Gain 1 - depth*lfo ranges from -32767 to 32768.
	localparam int GAIN_W = 18;

	// Queue between the front and the back end.
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Sine magnitude in Q1.14 from a first-quadrant angle x in Q2.30, using a
	// degree-15 Taylor series with flooring at every step.
	function automatic logic [MAG_W-1:0] sine_mag_q30(input longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		longint unsigned mag;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd210;
		sum  = sum - longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		mag = (unsigned'(sum) + 64'd32768) >> 16;
		if (mag > 64'd16384) begin
			mag = 64'd16384;
		end
		return MAG_W'(mag);
	endfunction

endpackage

FILE: sv/tlam_queue.sv
// ----------------------------------------------------------------------------
// tlam_queue
// Short register queue that decouples the sample front end from the
// modulation back end.
// ----------------------------------------------------------------------------
module tlam_queue #(
	parameter int WIDTH = 42
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [WIDTH-1:0]      push_data,
	input  logic                  pop,
	output logic [WIDTH-1:0]      pop_data,
	output tlam_pkg::q_status_t   status
);

	localparam int PTR_W = $clog2(tlam_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(tlam_pkg::QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(tlam_pkg::QUEUE_DEPTH);

	logic [WIDTH-1:0] entry_q [tlam_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full  = (count_q == FULL_CNT);
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_data     = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: sv/tlam_front.sv
// ----------------------------------------------------------------------------
// tlam_front
// Configuration registers, LFO phase accumulator and input acceptance. Each
// accepted sample is tagged with its phase and waveform and queued.
// ----------------------------------------------------------------------------
module tlam_front #(
	parameter int SAMPLE_BITS = tlam_pkg::SAMPLE_BITS_DEF,
	parameter int PHASE_BITS  = tlam_pkg::PHASE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [SAMPLE_BITS-1:0]          sample_in,
	input  logic                                   cfg_we,
	input  logic [tlam_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [tlam_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  tlam_pkg::q_status_t                    q_status,
	output logic                                   q_push,
	output logic [tlam_pkg::WAVE_W+PHASE_BITS+SAMPLE_BITS-1:0] q_data,
	output logic [tlam_pkg::DEPTH_W-1:0]           depth
);

	localparam int SUM_W = (PHASE_BITS > tlam_pkg::STEP_W) ? PHASE_BITS : tlam_pkg::STEP_W;

	logic [tlam_pkg::STEP_W-1:0]  step_q;
	logic [tlam_pkg::DEPTH_W-1:0] depth_q;
	logic [tlam_pkg::WAVE_W-1:0]  wave_q;
	logic [PHASE_BITS-1:0]        phase_q;
	logic [SUM_W-1:0]             phase_sum;

	assign in_stall  = q_status.full;
	assign q_push    = in_valid && !q_status.full;
	assign q_data    = {wave_q, phase_q, sample_in};
	assign depth     = depth_q;
	assign phase_sum = SUM_W'(phase_q) + SUM_W'(step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= tlam_pkg::STEP_RESET;
			depth_q <= tlam_pkg::DEPTH_RESET;
			wave_q  <= tlam_pkg::WAVE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tlam_pkg::CFG_PHASE_STEP: begin
					step_q <= cfg_data;
				end
				tlam_pkg::CFG_DEPTH: begin
					depth_q <= cfg_data[tlam_pkg::DEPTH_W-1:0];
				end
				tlam_pkg::CFG_WAVEFORM: begin
					wave_q <= cfg_data[tlam_pkg::WAVE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// The phase tagged on a sample is the one before the advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (q_push) begin
			phase_q <= phase_sum[PHASE_BITS-1:0];
		end
	end

endmodule

FILE: sv/tlam_back.sv
// ----------------------------------------------------------------------------
// tlam_back
// Modulation engine: derives the LFO value for a queued sample, forms the
// gain and scales the sample into the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlam_back #(
	parameter int SAMPLE_BITS        = tlam_pkg::SAMPLE_BITS_DEF,
	parameter int PHASE_BITS         = tlam_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_ENTRIES = tlam_pkg::SINE_ENTRIES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  tlam_pkg::q_status_t                    q_status,
	output logic                                   q_pop,
	input  logic [tlam_pkg::WAVE_W+PHASE_BITS+SAMPLE_BITS-1:0] q_data,
	input  logic [tlam_pkg::DEPTH_W-1:0]           depth,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [SAMPLE_BITS-1:0]          sample_out
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_IDX  = 3'd1;
	localparam logic [2:0] ST_LFO  = 3'd2;
	localparam logic [2:0] ST_GAIN = 3'd3;
	localparam logic [2:0] ST_PROD = 3'd4;

	localparam int KW        = $clog2(SINE_TABLE_ENTRIES);
	localparam int IDX_W     = PHASE_BITS + $clog2(SINE_TABLE_ENTRIES + 1);
	localparam int HALF_K    = SINE_TABLE_ENTRIES / 2;
	localparam int QUARTER_K = SINE_TABLE_ENTRIES / 4;
	localparam int QW        = $clog2(QUARTER_K + 1);
	localparam int SP_W      = PHASE_BITS + tlam_pkg::SLOPE_GAIN_W;
	localparam int PROD_W    = SAMPLE_BITS + tlam_pkg::GAIN_W;
	localparam int QS_W      = PROD_W - 15;
	localparam int TRI_SH    = PHASE_BITS - 16;

	localparam logic [PHASE_BITS-1:0] HALF_P   = PHASE_BITS'(64'd1 << (PHASE_BITS - 1));
	localparam logic [PHASE_BITS-1:0] QTR_P    = PHASE_BITS'(64'd1 << (PHASE_BITS - 2));
	localparam logic [PHASE_BITS-1:0] THREEQ_P = HALF_P + QTR_P;
	localparam logic [PHASE_BITS-1:0] SLOPE_A  = PHASE_BITS'((64'd48 << PHASE_BITS) / 64'd100);
	localparam logic [PHASE_BITS-1:0] SLOPE_B  = PHASE_BITS'((64'd98 << PHASE_BITS) / 64'd100);

	localparam logic signed [QS_W-1:0] Q_MAX = QS_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [QS_W-1:0] Q_MIN = QS_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

	// Quarter-wave sine magnitude table, built at elaboration.
	logic [tlam_pkg::MAG_W-1:0] sine_mag [QUARTER_K+1];

	for (genvar gi = 0; gi <= QUARTER_K; gi++) begin : g_sine
		localparam longint unsigned SX =
			(tlam_pkg::Q30_TWO_PI * 64'(gi)) / 64'(SINE_TABLE_ENTRIES);
		localparam logic [tlam_pkg::MAG_W-1:0] MAG = tlam_pkg::sine_mag_q30(SX);
		assign sine_mag[gi] = MAG;
	end

	logic [2:0]                        state_q;
	logic [2:0]                        state_d;
	logic                              out_load;
	logic                              out_valid_q;
	logic signed [SAMPLE_BITS-1:0]     sample_out_q;

	logic signed [SAMPLE_BITS-1:0]     sample_s1;
	logic [PHASE_BITS-1:0]             phase_s1;
	logic [tlam_pkg::WAVE_W-1:0]       wave_s1;
	logic [QW-1:0]                     m_s2;
	logic                              neg_s2;
	logic [tlam_pkg::SLOPE_GAIN_W-1:0] v_s2;
	logic [tlam_pkg::LFO_W-1:0]        lfo_s3;
	logic signed [tlam_pkg::GAIN_W-1:0] g_s4;

	logic [IDX_W-1:0]                  idx_prod;
	logic [KW-1:0]                     k_raw;
	logic [KW-1:0]                     k_fold;
	logic [KW-1:0]                     m_idx;
	logic                              k_neg;
	logic [PHASE_BITS-1:0]             slope_d;
	logic [SP_W-1:0]                   slope_prod;
	logic [tlam_pkg::MAG_W-1:0]        mag;
	logic [PHASE_BITS-1:0]             tri_d;
	logic [PHASE_BITS-1:0]             tri_sh;
	logic [tlam_pkg::LFO_W-1:0]        lfo_d;
	logic [31:0]                       depth_prod;
	logic signed [tlam_pkg::GAIN_W-1:0] g_d;
	logic signed [PROD_W-1:0]          prod;
	logic signed [QS_W-1:0]            q_wide;
	logic signed [SAMPLE_BITS-1:0]     q_sat;

	// Control
	assign out_load  = (state_q == ST_PROD) && (!out_valid_q || !out_stall);
	assign q_pop     = !q_status.empty && ((state_q == ST_IDLE) || out_load);
	assign out_valid = out_valid_q;
	assign sample_out = sample_out_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_status.empty) begin
					state_d = ST_IDX;
				end
			end
			ST_IDX: begin
				state_d = ST_LFO;
			end
			ST_LFO: begin
				state_d = ST_GAIN;
			end
			ST_GAIN: begin
				state_d = ST_PROD;
			end
			ST_PROD: begin
				if (out_load) begin
					state_d = q_status.empty ? ST_IDLE : ST_IDX;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Step 1: sine table index with quarter-wave folding, and the ramp of
	// the sloped square.
	assign idx_prod = IDX_W'(phase_s1) * IDX_W'(SINE_TABLE_ENTRIES);
	assign k_raw    = idx_prod[PHASE_BITS +: KW];
	assign k_neg    = (k_raw >= KW'(HALF_K));
	assign k_fold   = k_neg ? KW'(k_raw - KW'(HALF_K)) : k_raw;
	assign m_idx    = (k_fold > KW'(QUARTER_K)) ? KW'(KW'(HALF_K) - k_fold) : k_fold;

	assign slope_d    = (phase_s1 < HALF_P) ? PHASE_BITS'(phase_s1 - SLOPE_A)
	                                        : PHASE_BITS'(phase_s1 - SLOPE_B);
	assign slope_prod = SP_W'(slope_d) * SP_W'(tlam_pkg::SLOPE_GAIN);

	// Step 2: LFO value for the selected waveform.
	assign mag = sine_mag[m_s2];

	always_comb begin
		priority if (phase_s1 < QTR_P) begin
			tri_d = phase_s1;
		end else if (phase_s1 < THREEQ_P) begin
			tri_d = PHASE_BITS'(phase_s1 - QTR_P);
		end else begin
			tri_d = PHASE_BITS'(phase_s1 - THREEQ_P);
		end
	end
	assign tri_sh = tri_d >> TRI_SH;

	always_comb begin
		unique case (wave_s1)
			tlam_pkg::WAVE_SINE: begin
				lfo_d = neg_s2 ? tlam_pkg::LFO_MID - tlam_pkg::LFO_W'(mag)
				               : tlam_pkg::LFO_MID + tlam_pkg::LFO_W'(mag);
			end
			tlam_pkg::WAVE_TRIANGLE: begin
				priority if (phase_s1 < QTR_P) begin
					lfo_d = tlam_pkg::LFO_MID + tri_sh[tlam_pkg::LFO_W-1:0];
				end else if (phase_s1 < THREEQ_P) begin
					lfo_d = tlam_pkg::LFO_ONE - tri_sh[tlam_pkg::LFO_W-1:0];
				end else begin
					lfo_d = tri_sh[tlam_pkg::LFO_W-1:0];
				end
			end
			tlam_pkg::WAVE_SQUARE: begin
				lfo_d = (phase_s1 < HALF_P) ? tlam_pkg::LFO_ONE : '0;
			end
			tlam_pkg::WAVE_SLOPED: begin
				priority if (phase_s1 < SLOPE_A) begin
					lfo_d = tlam_pkg::LFO_ONE;
				end else if (phase_s1 < HALF_P) begin
					lfo_d = (v_s2 >= tlam_pkg::SLOPE_GAIN_W'(tlam_pkg::LFO_ONE)) ? '0
						: tlam_pkg::LFO_W'(tlam_pkg::SLOPE_GAIN_W'(tlam_pkg::LFO_ONE) - v_s2);
				end else if (phase_s1 < SLOPE_B) begin
					lfo_d = '0;
				end else begin
					lfo_d = (v_s2 > tlam_pkg::SLOPE_GAIN_W'(tlam_pkg::LFO_ONE))
						? tlam_pkg::LFO_ONE : v_s2[tlam_pkg::LFO_W-1:0];
				end
			end
			default: begin
				lfo_d = '0;
			end
		endcase
	end

	// Step 3: gain = 1.0 - depth * lfo, floored.
	assign depth_prod = 32'(depth) * 32'(lfo_s3);
	assign g_d        = 18'sd32768 - $signed({1'b0, depth_prod[31:15]});

	// Step 4: sample times gain, floored and saturated.
	assign prod   = PROD_W'(sample_s1) * PROD_W'(g_s4);
	assign q_wide = prod[PROD_W-1:15];

	always_comb begin
		priority if (q_wide > Q_MAX) begin
			q_sat = Q_MAX[SAMPLE_BITS-1:0];
		end else if (q_wide < Q_MIN) begin
			q_sat = Q_MIN[SAMPLE_BITS-1:0];
		end else begin
			q_sat = q_wide[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			sample_s1 <= q_data[SAMPLE_BITS-1:0];
			phase_s1  <= q_data[SAMPLE_BITS +: PHASE_BITS];
			wave_s1   <= q_data[SAMPLE_BITS+PHASE_BITS +: tlam_pkg::WAVE_W];
		end
		if (state_q == ST_IDX) begin
			m_s2   <= QW'(m_idx);
			neg_s2 <= k_neg;
			v_s2   <= slope_prod[PHASE_BITS +: tlam_pkg::SLOPE_GAIN_W];
		end
		if (state_q == ST_LFO) begin
			lfo_s3 <= lfo_d;
		end
		if (state_q == ST_GAIN) begin
			g_s4 <= g_d;
		end
		if (out_load) begin
			sample_out_q <= q_sat;
		end
	end

	`ASSERT_IMPL(a_pop_needs_item, q_pop, !q_status.empty, "pop from an empty queue")
	`ASSERT_NEXT(a_pop_starts_work, q_pop, state_q == ST_IDX, "popped item did not start")
	`ASSERT_IMPL(a_out_from_prod, $rose(out_valid_q), $past(state_q) == ST_PROD,
		"result appeared outside the product step")
	`ASSERT_IMPL(a_lfo_range, state_q == ST_GAIN, lfo_s3 <= tlam_pkg::LFO_ONE,
		"LFO value above 1.0")

endmodule

FILE: sv/tremolo_lfo_amplitude_modulator_core.sv
// ----------------------------------------------------------------------------
// tremolo_lfo_amplitude_modulator_core
// Tremolo effect: each signed audio sample is scaled by 1 - depth * lfo, with
// the LFO taken from a phase accumulator in one of four waveforms.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                          Transfer when
//   -------   ------------------------------   ------------------------------
//   input     in_valid, in_stall, sample_in    in_valid high, in_stall low
//   output    out_valid, out_stall, sample_out out_valid high, out_stall low
//   config    cfg_we, cfg_index, cfg_data      cfg_we high
//
// An item goes through the back end in steps: index and slope multiply, LFO
// selection, depth product, sample product. The back end can hold a single
// item, so it takes a new sample only once it is through with the last one.
// From the input transfer a sample goes through the queue and these back-end
// steps into the output register; it may also wait in the queue or on a
// stalled output.
// Reset clears the phase to zero and loads the register reset values; no
// sweep is needed after reset.
// A stalled output holds its result while the two-entry queue keeps taking
// samples, so the input stalls only once the queue is full.
//
// Configuration registers:
//   index 0  phase_step  24 bits, phase increment per sample
//   index 1  depth       16 bits, Q1.15 modulation depth
//   index 2  waveform     2 bits, sine, triangle, square, sloped square
// A write with any other index has no effect. Registers are to be written only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module tremolo_lfo_amplitude_modulator_core #(
	parameter int SAMPLE_BITS        = tlam_pkg::SAMPLE_BITS_DEF,
	parameter int PHASE_BITS         = tlam_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_ENTRIES = tlam_pkg::SINE_ENTRIES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [SAMPLE_BITS-1:0]      sample_in,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [SAMPLE_BITS-1:0]      sample_out,
	input  logic                               cfg_we,
	input  logic [tlam_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tlam_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// One queue entry carries the waveform code, the phase at which the
	// sample is modulated, and the sample itself.
	localparam int ENTRY_W = tlam_pkg::WAVE_W + PHASE_BITS + SAMPLE_BITS;

	tlam_pkg::q_status_t          q_status;
	logic                         q_push;
	logic                         q_pop;
	logic [ENTRY_W-1:0]           q_wr_data;
	logic [ENTRY_W-1:0]           q_rd_data;
	logic [tlam_pkg::DEPTH_W-1:0] depth;

	// Front end: registers, phase accumulator, input acceptance. The phase
	// advances on every accepted sample, so the sequence of phases matches
	// the order of samples regardless of how long the back end takes.
	tlam_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.PHASE_BITS  (PHASE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_in (sample_in),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_status  (q_status),
		.q_push    (q_push),
		.q_data    (q_wr_data),
		.depth     (depth)
	);

	// Queue that lets the front end keep accepting while the back end works
	// or waits on a stalled output.
	tlam_queue #(
		.WIDTH (ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wr_data),
		.pop       (q_pop),
		.pop_data  (q_rd_data),
		.status    (q_status)
	);

	// Back end: LFO evaluation, gain and sample product, output register.
	tlam_back #(
		.SAMPLE_BITS        (SAMPLE_BITS),
		.PHASE_BITS         (PHASE_BITS),
		.SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_status   (q_status),
		.q_pop      (q_pop),
		.q_data     (q_rd_data),
		.depth      (depth),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out)
	);

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tremolo core. A scoreboard class keeps its own
// copy of the LFO phase and registers, predicts each modulated sample, and
// checks the results in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------

import tlam_pkg::*;

typedef logic signed [SAMPLE_BITS_DEF-1:0] audio_t;

class tremolo_scoreboard;
	logic [STEP_W-1:0]          step_reg;
	logic [DEPTH_W-1:0]         depth_reg;
	logic [WAVE_W-1:0]          wave_reg;
	logic [PHASE_BITS_DEF-1:0]  phase_acc;
	longint unsigned            sine_rom[SINE_ENTRIES_DEF];
	audio_t                     awaited_samples[$];
	int                         failures;
	int                         checked;

	function new();
		step_reg  = STEP_RESET;
		depth_reg = DEPTH_RESET;
		wave_reg  = WAVE_RESET;
		phase_acc = '0;
		failures  = 0;
		checked   = 0;
		for (int k = 0; k < SINE_ENTRIES_DEF; k++) begin
			sine_rom[k] = rom_entry(k);
		end
	endfunction

	// Table entry: folded quarter-wave angle, Taylor series in Q2.30, then
	// rounded to Q1.14 and mirrored around mid-scale.
	function longint unsigned rom_entry(longint unsigned k);
		longint unsigned n;
		longint unsigned m;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned mag;
		longint          acc;
		bit              neg;
		n   = SINE_ENTRIES_DEF;
		neg = 1'b0;
		k   = k % n;
		if (k >= n / 2) begin
			neg = 1'b1;
			k   = k - n / 2;
		end
		m = k;
		if (m > n / 4) begin
			m = n / 2 - m;
		end
		x    = (Q30_TWO_PI * m) / n;
		x2   = (x * x) >> 30;
		term = x;
		acc  = longint'(x);
		for (int i = 1; i <= 7; i++) begin
			term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
			if (i % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		mag = (64'(acc) + 32768) >> 16;
		if (mag > MAG_MAX) begin
			mag = MAG_MAX;
		end
		return neg ? LFO_MID - mag : LFO_MID + mag;
	endfunction

	function longint unsigned lfo_level(longint unsigned p);
		longint unsigned f;
		longint unsigned a;
		longint unsigned b;
		longint unsigned v;
		f = 64'd1 << PHASE_BITS_DEF;
		a = (48 * f) / 100;
		b = (98 * f) / 100;
		case (wave_reg)
			WAVE_TRIANGLE: begin
				if (p < f / 4) begin
					return LFO_MID + ((p * 65536) >> PHASE_BITS_DEF);
				end
				if (p < (3 * f) / 4) begin
					return LFO_ONE - (((p - f / 4) * 65536) >> PHASE_BITS_DEF);
				end
				return ((p - (3 * f) / 4) * 65536) >> PHASE_BITS_DEF;
			end
			WAVE_SQUARE: begin
				return (p < f / 2) ? LFO_ONE : 0;
			end
			WAVE_SLOPED: begin
				if (p < a) begin
					return LFO_ONE;
				end
				if (p < f / 2) begin
					v = ((p - a) * SLOPE_GAIN) >> PHASE_BITS_DEF;
					return (v >= LFO_ONE) ? 0 : LFO_ONE - v;
				end
				if (p < b) begin
					return 0;
				end
				v = ((p - b) * SLOPE_GAIN) >> PHASE_BITS_DEF;
				return (v > LFO_ONE) ? LFO_ONE : v;
			end
			default: begin
				return sine_rom[(p * SINE_ENTRIES_DEF) >> PHASE_BITS_DEF];
			end
		endcase
	endfunction

	// Modulated sample at the current phase; the phase moves on afterwards.
	function audio_t apply_tremolo(audio_t x);
		longint gain;
		longint prod;
		longint q;
		gain = 32768 - longint'((64'(depth_reg) * lfo_level(64'(phase_acc))) >> 15);
		prod = longint'(x) * gain;
		q    = prod >>> 15;
		if (q > 32767) begin
			q = 32767;
		end
		if (q < -32768) begin
			q = -32768;
		end
		phase_acc = phase_acc + step_reg;
		return audio_t'(q);
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_PHASE_STEP: step_reg  = data[STEP_W-1:0];
			CFG_DEPTH:      depth_reg = data[DEPTH_W-1:0];
			CFG_WAVEFORM:   wave_reg  = data[WAVE_W-1:0];
			default: ;
		endcase
	endfunction

	function void note_sample(audio_t x);
		awaited_samples.push_back(apply_tremolo(x));
	endfunction

	function void check_sample(audio_t got);
		audio_t want;
		checked++;
		if (awaited_samples.size() == 0) begin
			$error("sample_out: no result expected, got %0d", got);
			failures++;
		end else begin
			want = awaited_samples.pop_front();
			if (got !== want) begin
				$error("sample_out mismatch: expected %0d, got %0d", want, got);
				failures++;
			end
		end
	endfunction

	function int pending();
		return awaited_samples.size();
	endfunction
endclass

module testbench;

	// Generous ceiling on the whole run, far above the slowest legal run.
	localparam int LIMIT_CYCLES  = 400000;
	// Quiet cycles after the last result before registers may change.
	localparam int SETTLE_CYCLES = 8;
	// An index past the register list; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    in_valid  = 1'b0;
	audio_t                  sample_in = '0;
	logic                    out_stall = 1'b0;
	logic                    cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data  = '0;
	logic                    in_stall;
	logic                    out_valid;
	audio_t                  sample_out;

	int tx_idle_pct    = 0;
	int rx_idle_pct    = 0;
	int cycle_count    = 0;
	int samples_sent   = 0;
	int settings_used  = 0;

	tremolo_scoreboard sb = new();

	tremolo_lfo_amplitude_modulator_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Monitors for both channels, the random output stall and the run limit.
	// Everything here reads the values that were present at the clock edge,
	// which is exactly what the core itself sampled for each transfer.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && in_valid && !in_stall) begin
			sb.note_sample(sample_in);
		end
		if (arst_n && out_valid && !out_stall) begin
			sb.check_sample(sample_out);
		end
		out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, sb.pending());
			$display("** tremolo_lfo_amplitude_modulator_core: FAILED **");
			$finish;
		end
	end

	// One input transfer. The sender may idle first; once valid is raised the
	// sample is held until the core takes it.
	task automatic send_sample(input audio_t x);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= x;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		samples_sent++;
	endtask

	// Stop sending, wait for every outstanding result, then let the pipeline
	// go quiet. Register writes are only safe after this.
	task automatic settle_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [STEP_W-1:0] st, input logic [DEPTH_W-1:0] dp,
			input logic [WAVE_W-1:0] wv);
		write_reg(CFG_PHASE_STEP, CFG_DATA_W'(st));
		write_reg(CFG_DEPTH, CFG_DATA_W'(dp));
		write_reg(CFG_WAVEFORM, CFG_DATA_W'(wv));
		settings_used++;
	endtask

	// Random register set. Steps range from frozen to full-scale wraps, and
	// depth sometimes goes past unity so that the gain turns negative.
	task automatic pick_settings();
		logic [STEP_W-1:0]  st;
		logic [DEPTH_W-1:0] dp;
		case ($urandom_range(0, 5))
			0:       st = '0;
			1:       st = '1;
			2:       st = STEP_W'(24'h800000);
			3:       st = STEP_W'($urandom_range(1, 20000));
			default: st = STEP_W'($urandom);
		endcase
		case ($urandom_range(0, 5))
			0:       dp = '0;
			1:       dp = DEPTH_RESET;
			2:       dp = '1;
			3:       dp = DEPTH_W'($urandom);
			default: dp = DEPTH_W'($urandom_range(0, 32768));
		endcase
		if ($urandom_range(0, 3) == 0) begin
			write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
		end
		configure(st, dp, WAVE_W'($urandom_range(0, 3)));
	endtask

	// Mostly full-range samples, with the rails and the values around zero
	// mixed in now and then.
	function automatic audio_t pick_sample();
		case ($urandom_range(0, 15))
			0:       return audio_t'(16'h8000);
			1:       return audio_t'(16'h7FFF);
			2:       return audio_t'(16'hFFFF);
			3:       return '0;
			default: return audio_t'($urandom);
		endcase
	endfunction

	initial begin
		int n;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: sine at phase zero, full depth, slow step.
		send_sample(audio_t'(16'h8000));
		send_sample(audio_t'(16'h7FFF));
		send_sample('0);
		send_sample(audio_t'(16'hFFFF));
		settle_block();

		// Depth past unity on a half-cycle square: the gain swings between
		// one and almost minus one on alternate samples.
		configure(STEP_W'(24'h800000), '1, WAVE_SQUARE);
		send_sample(audio_t'(16'h7FFF));
		send_sample(audio_t'(16'h8000));
		send_sample(audio_t'(16'h7FFF));
		send_sample(audio_t'(16'h8000));
		settle_block();

		// A write past the register list must leave every register alone.
		write_reg(CFG_UNUSED, '1);
		configure(STEP_W'(24'h400000), DEPTH_RESET, WAVE_TRIANGLE);
		send_sample(audio_t'(16'h8000));
		send_sample(audio_t'(16'h7FFF));
		send_sample(audio_t'(16'h0001));
		send_sample(audio_t'(16'hFFFF));
		send_sample(audio_t'(16'h7FFF));
		settle_block();

		// Largest step wraps the phase backwards by one each sample.
		configure('1, '0, WAVE_SLOPED);
		send_sample(audio_t'(16'h7FFF));
		send_sample(audio_t'(16'h8000));
		settle_block();
		configure('0, DEPTH_RESET, WAVE_SLOPED);
		send_sample(audio_t'(16'h8000));
		send_sample(audio_t'(16'h7FFF));
		settle_block();

		// Random part in three idling regimes: slow receiver, slow sender,
		// then full speed on both sides. Each segment ends with the sender
		// holding off until all results are back, then new registers go in.
		for (int regime = 0; regime < 3; regime++) begin
			case (regime)
				0: begin
					tx_idle_pct = 11;
					rx_idle_pct = 60;
				end
				1: begin
					tx_idle_pct = 60;
					rx_idle_pct = 11;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 6; seg++) begin
				pick_settings();
				n = $urandom_range(50, 95);
				repeat (n) send_sample(pick_sample());
				settle_block();
			end
		end

		$display("Covered %0d samples under %0d register settings: all four LFO shapes,",
			samples_sent, settings_used);
		$display("gains below zero, phase wrap, ignored writes; %0d results compared.",
			sb.checked);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("** tremolo_lfo_amplitude_modulator_core: PASSED **");
		end else begin
			$display("** tremolo_lfo_amplitude_modulator_core: FAILED **");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/tlam_pkg.sv
sv/tlam_queue.sv
sv/tlam_front.sv
sv/tlam_back.sv
sv/tremolo_lfo_amplitude_modulator_core.sv
bench/testbench.sv
